// ===== rtl/core/positional_list_store_macros.svh =====
// Assertion macros for the positional list store.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define PLS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pls: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define PLS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pls: next-cycle check failed");

`endif

// ===== rtl/core/pls_pkg.sv =====
// Shared types, codes and sizes for the positional list store.
// No dependencies; every other file but the assertion macro header imports it.
package pls_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W   = 3;
   localparam int POS_W  = 8;
   localparam int DATA_W = 32;
   localparam int ST_W   = 3;
   localparam int LEN_W  = 5;

   typedef logic [OP_W-1:0]          op_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ST_W-1:0]          status_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   localparam op_type OP_INS_FRONT = 3'd0;
   localparam op_type OP_INS_BACK  = 3'd1;
   localparam op_type OP_INS_POS   = 3'd2;
   localparam op_type OP_DEL_FRONT = 3'd3;
   localparam op_type OP_DEL_BACK  = 3'd4;
   localparam op_type OP_DEL_POS   = 3'd5;
   localparam op_type OP_REVERSE   = 3'd6;
   localparam op_type OP_READ_OUT  = 3'd7;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_EMPTY   = 3'd1;
   localparam status_type ST_INVALID = 3'd2;
   localparam status_type ST_BOUNDS  = 3'd3;
   localparam status_type ST_FULL    = 3'd4;

   // What every cell of the chain does when clocked.
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_HOLD   = 2'd0;
   localparam mode_type MODE_INSERT = 2'd1;
   localparam mode_type MODE_DELETE = 2'd2;
   localparam mode_type MODE_ROTATE = 2'd3;

   typedef struct packed {
      mode_type mode;
      idx_type  index;
      data_type value;
   } chain_ctrl_type;

endpackage

// ===== rtl/core/pls_req_if.sv =====
// Request channel of the positional list store: valid/ready plus payload.
// Depends on pls_pkg.
interface pls_req_if;
   import pls_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   pos_type  position;
   data_type value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

// ===== rtl/core/pls_rsp_if.sv =====
// Response channel of the positional list store: valid/ready plus payload.
// Depends on pls_pkg.
interface pls_rsp_if;
   import pls_pkg::*;

   logic       valid;
   logic       ready;
   data_type   element;
   status_type status;
   len_type    length;
   logic       last;

   modport source (output valid, output element, output status, output length,
                   output last, input ready);
   modport sink   (input valid, input element, input status, input length,
                   input last, output ready);
endinterface

// ===== rtl/core/pls_cell.sv =====
// One storage cell of the list chain: holds a single element.
// Depends on pls_pkg.
module pls_cell (
   input  logic                   clock,
   input  pls_pkg::chain_ctrl_type ctrl,
   input  pls_pkg::idx_type       cell_index,
   input  pls_pkg::data_type      left_data,
   input  pls_pkg::data_type      right_data,
   input  pls_pkg::data_type      front_data,
   output pls_pkg::data_type      data
);
   import pls_pkg::*;

   data_type data_ff;
   data_type data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.mode)
         MODE_INSERT: begin
            if (cell_index > ctrl.index) begin
               data_in = left_data;
            end else if (cell_index == ctrl.index) begin
               data_in = ctrl.value;
            end
         end
         MODE_DELETE: begin
            if (cell_index >= ctrl.index) begin
               data_in = right_data;
            end
         end
         MODE_ROTATE: begin
            // The prefix up to the given index turns left by one place.
            if (cell_index < ctrl.index) begin
               data_in = right_data;
            end else if (cell_index == ctrl.index) begin
               data_in = front_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/core/pls_chain.sv =====
// Row of list cells, each wired to its neighbours (zero past either end) and to the front cell.
// Depends on pls_pkg and pls_cell.
module pls_chain (
   input  logic                    clock,
   input  pls_pkg::chain_ctrl_type ctrl,
   output pls_pkg::data_type       front
);
   import pls_pkg::*;

   data_type cell_q [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_d;
      data_type right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[i+1];
      end

      pls_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .front_data (cell_q[0]),
         .data       (cell_q[i])
      );
   end

   assign front = cell_q[0];

endmodule

// ===== rtl/core/positional_list_store.sv =====
// Channel  | Direction | Carries
// req_ch   | in        | operation, position, value
// rsp_ch   | out       | element, status, length, last
//
// Inserts and front or position deletes shift the cells at once, towards or away
// from a neighbour; a back delete only lowers the count. A reverse runs prefix
// rotations in the cell chain over shrinking prefixes; a read out enters its read
// state, then sends one element per cycle, paced by rsp_ch. Results leave through
// one output register, so a request is taken while the last result is being
// transferred. Reset clears only control state; cells stay undefined until written.
`include "positional_list_store_macros.svh"

module positional_list_store (
   input logic      clock,
   input logic      reset,
   pls_req_if.sink  req_ch,
   pls_rsp_if.source rsp_ch
);
   import pls_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_REVERSE = 2'd1;
   localparam logic [1:0] S_READ    = 2'd2;

   logic [1:0] state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;
   idx_type    step_ff, step_in;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_element_ff;
   status_type rsp_status_ff;
   len_type    rsp_length_ff;
   logic       rsp_last_ff;

   logic           out_free;
   logic           accept;
   logic           load;
   data_type       ld_element;
   status_type     ld_status;
   logic           ld_last;
   chain_ctrl_type ctrl;
   data_type       front;
   logic           full;
   logic           empty;
   logic [POS_W:0] pos_ext;
   logic [POS_W:0] cnt_ext;
   idx_type        last_idx;
   logic           rsp_is_error;

   pls_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .front (front)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign full     = (cnt_ff == CNT_W'(CAPACITY));
   assign empty    = (cnt_ff == '0);
   assign pos_ext  = {1'b0, req_ch.position};
   assign cnt_ext  = (POS_W + 1)'(cnt_ff);
   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      load       = 1'b0;
      ld_element = '0;
      ld_status  = ST_OK;
      ld_last    = 1'b1;
      ctrl.mode  = MODE_HOLD;
      ctrl.index = '0;
      ctrl.value = req_ch.value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load = 1'b1;
               unique case (req_ch.operation)
                  OP_INS_FRONT: begin
                     if (full) begin
                        ld_status = ST_FULL;
                     end else begin
                        ctrl.mode = MODE_INSERT;
                        cnt_in    = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_INS_BACK: begin
                     if (full) begin
                        ld_status = ST_FULL;
                     end else begin
                        ctrl.mode  = MODE_INSERT;
                        ctrl.index = IDX_W'(cnt_ff);
                        cnt_in     = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_INS_POS: begin
                     if (req_ch.position == '0) begin
                        ld_status = ST_INVALID;
                     end else if (pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
                        ld_status = ST_BOUNDS;
                     end else if (full) begin
                        ld_status = ST_FULL;
                     end else begin
                        ctrl.mode  = MODE_INSERT;
                        ctrl.index = IDX_W'(req_ch.position - POS_W'(1));
                        cnt_in     = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_DEL_FRONT: begin
                     if (empty) begin
                        ld_status = ST_EMPTY;
                     end else begin
                        ctrl.mode = MODE_DELETE;
                        cnt_in    = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_DEL_BACK: begin
                     if (empty) begin
                        ld_status = ST_EMPTY;
                     end else begin
                        cnt_in = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_DEL_POS: begin
                     if (empty) begin
                        ld_status = ST_EMPTY;
                     end else if (req_ch.position == '0) begin
                        ld_status = ST_INVALID;
                     end else if (pos_ext > cnt_ext) begin
                        ld_status = ST_BOUNDS;
                     end else begin
                        ctrl.mode  = MODE_DELETE;
                        ctrl.index = IDX_W'(req_ch.position - POS_W'(1));
                        cnt_in     = cnt_ff - CNT_W'(1);
                     end
                  end
                  OP_REVERSE: begin
                     // Status goes out now; the count is unchanged and no request
                     // is taken until the rotation passes are done.
                     if (empty) begin
                        ld_status = ST_EMPTY;
                     end else if (cnt_ff != CNT_W'(1)) begin
                        state_in = S_REVERSE;
                        step_in  = last_idx;
                     end
                  end
                  default: begin
                     if (empty) begin
                        ld_status = ST_EMPTY;
                     end else begin
                        load     = 1'b0;
                        state_in = S_READ;
                        step_in  = '0;
                     end
                  end
               endcase
            end
         end
         S_REVERSE: begin
            // Each pass moves the front element to the end of a shrinking prefix.
            ctrl.mode  = MODE_ROTATE;
            ctrl.index = step_ff;
            step_in    = step_ff - IDX_W'(1);
            if (step_ff == IDX_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            // The whole list rotates once per transfer, so it is restored at the end.
            if (out_free) begin
               load       = 1'b1;
               ld_element = front;
               ld_last    = (step_ff == last_idx);
               ctrl.mode  = MODE_ROTATE;
               ctrl.index = last_idx;
               step_in    = step_ff + IDX_W'(1);
               if (step_ff == last_idx) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_element_ff <= ld_element;
         rsp_status_ff  <= ld_status;
         rsp_length_ff  <= LEN_W'(cnt_in);
         rsp_last_ff    <= ld_last;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.length  = rsp_length_ff;
   assign rsp_ch.last    = rsp_last_ff;

   assign rsp_is_error = rsp_valid_ff && (rsp_status_ff != ST_OK);

   `PLS_ASSERT_NOW(a_count_bound, 1'b1, cnt_ff <= CNT_W'(CAPACITY))
   `PLS_ASSERT_NOW(a_busy_nonempty, state_ff != S_IDLE, !empty && !req_ch.ready)
   `PLS_ASSERT_NOW(a_error_is_single, rsp_is_error, rsp_last_ff && rsp_element_ff == '0)
   `PLS_ASSERT_NEXT(a_count_needs_transfer, !accept, $stable(cnt_ff))

endmodule
